>>> rtl/tas_pkg.sv
// ----------------------------------------------------------------------------
// Timed actuation sequencer package
// Shared widths, phase codes, register indexes and channel payload types.
// ----------------------------------------------------------------------------
`default_nettype none

package tas_pkg;

    localparam int DUR_W     = 20;
    localparam int CFG_IDX_W = 3;

    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    localparam logic [DUR_W-1:0] PRESS_DURATION_RST      = DUR_W'(200);
    localparam logic [DUR_W-1:0] READY_TIMEOUT_RST       = DUR_W'(60000);
    localparam logic [DUR_W-1:0] LEVER_MOVE_DURATION_RST = DUR_W'(1000);
    localparam logic [DUR_W-1:0] BREW_DURATION_RST       = DUR_W'(30000);
    localparam logic [DUR_W-1:0] DONE_HOLD_DURATION_RST  = DUR_W'(5000);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_PRESS   = 3'd1,
        PH_WAIT    = 3'd2,
        PH_ACTUATE = 3'd3,
        PH_BREW    = 3'd4,
        PH_RETURN  = 3'd5,
        PH_DONE    = 3'd6,
        PH_ERROR   = 3'd7
    } phase_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PRESS_DURATION      = 3'd0,
        REG_READY_TIMEOUT       = 3'd1,
        REG_LEVER_MOVE_DURATION = 3'd2,
        REG_BREW_DURATION       = 3'd3,
        REG_DONE_HOLD_DURATION  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [DUR_W-1:0] press_duration;
        logic [DUR_W-1:0] ready_timeout;
        logic [DUR_W-1:0] lever_move_duration;
        logic [DUR_W-1:0] brew_duration;
        logic [DUR_W-1:0] done_hold_duration;
    } durations_t;

    typedef struct packed {
        phase_t phase;
        logic   button_press;
        logic   lever_brew;
        logic   error_flag;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/tas_ifs.sv
// ----------------------------------------------------------------------------
// Timed actuation sequencer channel interfaces
// Valid/ready channels for ticks, status results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface tas_tick_if;
    logic valid;
    logic ready;
    logic start_request;
    logic machine_ready;

    modport source (output valid, output start_request, output machine_ready, input ready);
    modport sink   (input valid, input start_request, input machine_ready, output ready);
endinterface

interface tas_status_if;
    logic       valid;
    logic       ready;
    logic [2:0] phase;
    logic       button_press;
    logic       lever_brew;
    logic       error_flag;

    modport source (output valid, output phase, output button_press, output lever_brew,
                    output error_flag, input ready);
    modport sink   (input valid, input phase, input button_press, input lever_brew,
                    input error_flag, output ready);
endinterface

interface tas_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [tas_pkg::CFG_IDX_W-1:0] index;
    logic [tas_pkg::DUR_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/tas_cfg_regs.sv
// ----------------------------------------------------------------------------
// Timed actuation sequencer register file
// Holds the five phase durations; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_cfg_regs (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          wr_en,
    input  wire logic [tas_pkg::CFG_IDX_W-1:0] wr_index,
    input  wire logic [tas_pkg::DUR_W-1:0]     wr_data,
    output tas_pkg::durations_t                durations
);

    tas_pkg::durations_t dur_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_reg.press_duration      <= tas_pkg::PRESS_DURATION_RST;
            dur_reg.ready_timeout       <= tas_pkg::READY_TIMEOUT_RST;
            dur_reg.lever_move_duration <= tas_pkg::LEVER_MOVE_DURATION_RST;
            dur_reg.brew_duration       <= tas_pkg::BREW_DURATION_RST;
            dur_reg.done_hold_duration  <= tas_pkg::DONE_HOLD_DURATION_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                tas_pkg::REG_PRESS_DURATION:      dur_reg.press_duration      <= wr_data;
                tas_pkg::REG_READY_TIMEOUT:       dur_reg.ready_timeout       <= wr_data;
                tas_pkg::REG_LEVER_MOVE_DURATION: dur_reg.lever_move_duration <= wr_data;
                tas_pkg::REG_BREW_DURATION:       dur_reg.brew_duration       <= wr_data;
                tas_pkg::REG_DONE_HOLD_DURATION:  dur_reg.done_hold_duration  <= wr_data;
                default:                          ;
            endcase
        end
    end

    assign durations = dur_reg;

endmodule

`default_nettype wire

>>> rtl/tas_seq_core.sv
// ----------------------------------------------------------------------------
// Timed actuation sequencer core
// Phase register, saturating phase timer and latched start request.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_seq_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               tick_en,
    input  wire logic               start_request,
    input  wire logic               machine_ready,
    input  wire tas_pkg::durations_t durations,
    output tas_pkg::phase_t         cur_phase,
    output tas_pkg::result_t        result_next
);

    tas_pkg::phase_t           phase_reg, phase_next;
    logic [tas_pkg::DUR_W-1:0] elapsed_reg, elapsed_next;
    logic                      pending_reg, pending_next;
    logic [tas_pkg::DUR_W-1:0] elapsed_inc;
    logic                      pending_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= tas_pkg::PH_IDLE;
            elapsed_reg <= '0;
            pending_reg <= 1'b0;
        end
        else if (tick_en)
        begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            pending_reg <= pending_next;
        end
    end

    always_comb
    begin
        pending_now  = pending_reg | start_request;
        elapsed_inc  = (elapsed_reg == tas_pkg::DUR_MAX) ? elapsed_reg
                                                         : elapsed_reg + 1'b1;
        phase_next   = phase_reg;
        pending_next = pending_now;

        unique case (phase_reg)
            tas_pkg::PH_IDLE,
            tas_pkg::PH_ERROR:
            begin
                if (pending_now)
                begin
                    pending_next = 1'b0;
                    phase_next   = tas_pkg::PH_PRESS;
                end
            end
            tas_pkg::PH_PRESS:
                if (elapsed_inc >= durations.press_duration)
                    phase_next = tas_pkg::PH_WAIT;
            tas_pkg::PH_WAIT:
            begin
                // Ready takes priority over a timeout on the same tick.
                if (machine_ready)
                    phase_next = tas_pkg::PH_ACTUATE;
                else if (elapsed_inc >= durations.ready_timeout)
                    phase_next = tas_pkg::PH_ERROR;
            end
            tas_pkg::PH_ACTUATE:
                if (elapsed_inc >= durations.lever_move_duration)
                    phase_next = tas_pkg::PH_BREW;
            tas_pkg::PH_BREW:
                if (elapsed_inc >= durations.brew_duration)
                    phase_next = tas_pkg::PH_RETURN;
            tas_pkg::PH_RETURN:
                if (elapsed_inc >= durations.lever_move_duration)
                    phase_next = tas_pkg::PH_DONE;
            tas_pkg::PH_DONE:
                if (elapsed_inc >= durations.done_hold_duration)
                    phase_next = tas_pkg::PH_IDLE;
            default:
                phase_next = tas_pkg::PH_IDLE;
        endcase

        elapsed_next = (phase_next != phase_reg) ? '0 : elapsed_inc;

        result_next.phase        = phase_next;
        result_next.button_press = (phase_next == tas_pkg::PH_PRESS);
        result_next.lever_brew   = (phase_next == tas_pkg::PH_ACTUATE) ||
                                   (phase_next == tas_pkg::PH_BREW);
        result_next.error_flag   = (phase_next == tas_pkg::PH_ERROR);
    end

    assign cur_phase = phase_reg;

endmodule

`default_nettype wire

>>> rtl/tas_out_reg.sv
// ----------------------------------------------------------------------------
// Timed actuation sequencer result register
// One-deep output register; a new beat loads while the old one is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tas_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire tas_pkg::result_t result_in,
    input  wire logic             out_ready,
    output logic                  out_valid,
    output tas_pkg::result_t      result_out,
    output logic                  can_load
);

    logic             valid_reg;
    tas_pkg::result_t data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (load)
            valid_reg <= 1'b1;
        else if (out_ready)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= result_in;
    end

    assign can_load   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = data_reg;

endmodule

`default_nettype wire

>>> rtl/timed_actuation_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Timed actuation sequencer unit
// Eight-phase button and lever sequencer driven by one tick beat per ms.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Payload                                        Rate
//   -------  ---------  ---------------------------------------------  ---------------
//   tick     in         start_request, machine_ready                   1/cycle if ready
//   status   out        phase, button_press, lever_brew, error_flag    1 beat per tick
//   cfg      in         index (3 bits), data (20 bits)                 1 beat / cycle
//
// Each accepted tick beat updates the phase, timer and pending request at
// the accepting edge, and the result is loaded into the status register
// at the same edge, so it is presented on status in the following cycle.
// The tick channel stays ready as long as the status register is empty or
// its beat is taken in the same cycle; a stalled status sink stalls ticks.
// Reset is asynchronous and active low; it brings the sequencer to idle with
// a cleared timer and no pending request, and loads the default durations.
// The cfg channel is always ready and never waits on the sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

module timed_actuation_sequencer_unit (
    input  wire logic    clk,
    input  wire logic    rst_n,
    tas_tick_if.sink     tick,
    tas_status_if.source status,
    tas_cfg_if.sink      cfg
);

    tas_pkg::durations_t durations;
    tas_pkg::phase_t     cur_phase;
    tas_pkg::result_t    result_next;
    tas_pkg::result_t    result_out;
    logic                can_load;
    logic                tick_fire;

    // Register writes complete on any cycle; the index decode drops unknown codes.
    assign cfg.ready = 1'b1;

    tas_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (cfg.valid),
        .wr_index  (cfg.index),
        .wr_data   (cfg.data),
        .durations (durations)
    );

    // A tick beat is accepted whenever the status register can take its result.
    assign tick.ready = can_load;
    assign tick_fire  = tick.valid && can_load;

    tas_seq_core u_seq_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .tick_en       (tick_fire),
        .start_request (tick.start_request),
        .machine_ready (tick.machine_ready),
        .durations     (durations),
        .cur_phase     (cur_phase),
        .result_next   (result_next)
    );

    tas_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (tick_fire),
        .result_in  (result_next),
        .out_ready  (status.ready),
        .out_valid  (status.valid),
        .result_out (result_out),
        .can_load   (can_load)
    );

    assign status.phase        = result_out.phase;
    assign status.button_press = result_out.button_press;
    assign status.lever_brew   = result_out.lever_brew;
    assign status.error_flag   = result_out.error_flag;

    // The sequencer state only moves on an accepted tick beat.
    a_phase_holds_without_tick : assert property (
        @(posedge clk) disable iff (!rst_n)
        !tick_fire |=> $stable(cur_phase)
    ) else $error("phase changed without a tick beat");

    // A request seen in idle starts the press phase on that very tick.
    a_idle_start_press : assert property (
        @(posedge clk) disable iff (!rst_n)
        (tick_fire && tick.start_request && cur_phase == tas_pkg::PH_IDLE)
            |=> (cur_phase == tas_pkg::PH_PRESS)
    ) else $error("start request in idle did not enter press");

    // An empty status register never back-pressures the tick channel.
    a_ready_when_empty : assert property (
        @(posedge clk) disable iff (!rst_n)
        !status.valid |-> tick.ready
    ) else $error("tick stalled while the status register is empty");

    // A loaded result reports the phase that the sequencer has just entered.
    a_result_matches_state : assert property (
        @(posedge clk) disable iff (!rst_n)
        tick_fire |=> (status.valid && status.phase == cur_phase)
    ) else $error("status beat does not match the sequencer phase");

endmodule

`default_nettype wire
